// File: rtl/core/rcsp_pkg.sv
// Shared types and constants for the route command stream parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rcsp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_WIDTH = 8;
  localparam logic [CFG_WIDTH-1:0] TYPE_LOW_RESET  = 8'd1;
  localparam logic [CFG_WIDTH-1:0] TYPE_HIGH_RESET = 8'd4;

  typedef enum logic {
    CFG_TYPE_LOW  = 1'b0,
    CFG_TYPE_HIGH = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    TK_NONE        = 5'd0,
    TK_TYPE        = 5'd1,
    TK_GS_CHAR     = 5'd2,
    TK_GS_END      = 5'd3,
    TK_RELIABILITY = 5'd4,
    TK_ADDR_CHAR   = 5'd5,
    TK_ADDR_END    = 5'd6,
    TK_NODE_CHAR   = 5'd7,
    TK_NODE_END    = 5'd8,
    TK_CONTACT     = 5'd9,
    TK_START       = 5'd10,
    TK_END_TIME    = 5'd11,
    TK_BITRATE     = 5'd12,
    TK_CNODE_CHAR  = 5'd13,
    TK_CNODE_END   = 5'd14,
    TK_CLOSE       = 5'd15,
    TK_DONE        = 5'd16,
    TK_ERROR       = 5'd17
  } token_kind_t;

  // Structural characters of the command text, and the end mark.
  typedef enum logic [3:0] {
    P_NONE   = 4'd0,
    P_LPAREN = 4'd1,
    P_RPAREN = 4'd2,
    P_COMMA  = 4'd3,
    P_COLON  = 4'd4,
    P_LBRACK = 4'd5,
    P_RBRACK = 4'd6,
    P_LBRACE = 4'd7,
    P_RBRACE = 4'd8,
    P_END    = 4'd9
  } punct_t;

  typedef struct packed {
    punct_t punct;
    logic   digit;
    logic   id_ok;
    logic   addr_ok;
    logic   type_ok;
  } byte_cls_t;

  typedef struct packed {
    logic        restart;
    logic [7:0]  data;
    logic [63:0] now;
    byte_cls_t   cls;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/core/rcsp_front.sv
// Front end: type range registers and byte classification.
// Depends on rcsp_pkg; feeds rcsp_queue.
`default_nettype none

module rcsp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_index,
  input  wire logic [rcsp_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           req_type,
  input  wire logic [7:0]                     data_byte,
  input  wire logic [63:0]                    now_seconds,
  input  wire logic                           queue_full,
  output      logic                           push,
  output      rcsp_pkg::item_t                push_item
);
  import rcsp_pkg::*;

  localparam logic [7:0] ID_LO1 = 8'h21;
  localparam logic [7:0] ID_HI1 = 8'h5F;
  localparam logic [7:0] ID_LO2 = 8'h61;
  localparam logic [7:0] ID_HI2 = 8'h7A;
  localparam logic [7:0] TILDE  = 8'h7E;

  logic [CFG_WIDTH-1:0] type_low;
  logic [CFG_WIDTH-1:0] type_high;
  byte_cls_t            cls;
  logic                 is_digit;
  logic                 is_upper;
  logic                 is_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_low  <= TYPE_LOW_RESET;
      type_high <= TYPE_HIGH_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_TYPE_LOW) begin
        type_low <= cfg_data;
      end else begin
        type_high <= cfg_data;
      end
    end
  end

  assign is_digit = (data_byte >= "0") && (data_byte <= "9");
  assign is_upper = (data_byte >= "A") && (data_byte <= "Z");
  assign is_lower = (data_byte >= "a") && (data_byte <= "z");

  always_comb begin
    cls.digit   = is_digit;
    cls.addr_ok = is_digit || is_upper || is_lower;
    cls.id_ok   = ((data_byte >= ID_LO1) && (data_byte <= ID_HI1)) ||
                  ((data_byte >= ID_LO2) && (data_byte <= ID_HI2)) ||
                  (data_byte == TILDE);
    cls.type_ok = (data_byte >= type_low) && (data_byte <= type_high);
    unique case (data_byte)
      "(":     cls.punct = P_LPAREN;
      ")":     cls.punct = P_RPAREN;
      ",":     cls.punct = P_COMMA;
      ":":     cls.punct = P_COLON;
      "[":     cls.punct = P_LBRACK;
      "]":     cls.punct = P_RBRACK;
      "{":     cls.punct = P_LBRACE;
      "}":     cls.punct = P_RBRACE;
      8'hFF:   cls.punct = P_END;
      default: cls.punct = P_NONE;
    endcase
  end

  assign in_ready          = !queue_full;
  assign push              = in_valid && in_ready;
  assign push_item.restart = req_type;
  assign push_item.data    = data_byte;
  assign push_item.now     = now_seconds;
  assign push_item.cls     = cls;

endmodule

`default_nettype wire

// File: rtl/core/rcsp_queue.sv
// Short queue of classified bytes between the front and the grammar engine.
// Depends on rcsp_pkg for the entry type.
`default_nettype none

module rcsp_queue #(
  parameter int Depth = rcsp_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rcsp_pkg::item_t push_item,
  output      logic            full,
  output      logic            head_valid,
  output      rcsp_pkg::item_t head_item,
  input  wire logic            pop
);
  import rcsp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

endmodule

`default_nettype wire

// File: rtl/core/rcsp_back.sv
// Back end: grammar state machine, number accumulator and result register.
// Depends on rcsp_pkg; takes classified bytes from rcsp_queue.
`default_nettype none

module rcsp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire rcsp_pkg::item_t head_item,
  output      logic            pop,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      logic [1:0]      parse_status,
  output      logic [4:0]      token_kind,
  output      logic [63:0]     token_value
);
  import rcsp_pkg::*;

  localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;
  localparam logic [63:0] REL_MIN   = 64'd100;
  localparam logic [63:0] REL_MAX   = 64'd1000;

  typedef enum logic [24:0] {
    S_TYPE          = 25'd1 << 0,
    S_GS_OPEN       = 25'd1 << 1,
    S_GS_ID         = 25'd1 << 2,
    S_REL_SEP       = 25'd1 << 3,
    S_REL           = 25'd1 << 4,
    S_ADDR_OPEN     = 25'd1 << 5,
    S_ADDR          = 25'd1 << 6,
    S_ADDR_SEP      = 25'd1 << 7,
    S_NODES_OPEN    = 25'd1 << 8,
    S_NODE_OPEN     = 25'd1 << 9,
    S_NODE_ID       = 25'd1 << 10,
    S_NODE_SEP      = 25'd1 << 11,
    S_NC_SEP        = 25'd1 << 12,
    S_CONTACTS_OPEN = 25'd1 << 13,
    S_CONTACT_OPEN  = 25'd1 << 14,
    S_START         = 25'd1 << 15,
    S_END           = 25'd1 << 16,
    S_RATE          = 25'd1 << 17,
    S_CNODES_OPEN   = 25'd1 << 18,
    S_CNODE_OPEN    = 25'd1 << 19,
    S_CNODE_ID      = 25'd1 << 20,
    S_CNODE_SEP     = 25'd1 << 21,
    S_CONTACT_CLOSE = 25'd1 << 22,
    S_CONTACT_SEP   = 25'd1 << 23,
    S_FINAL         = 25'd1 << 24
  } stage_t;

  stage_t      stage, stage_next;
  status_t     status, status_next;
  logic [63:0] acc, acc_next;
  logic [63:0] start_time, start_time_next;

  token_kind_t kind_reg;
  status_t     status_reg;
  logic [63:0] value_reg;

  token_kind_t kind;
  logic [63:0] value;
  logic        err;

  punct_t      p;
  logic [7:0]  ch;
  logic [3:0]  digit;
  logic [63:0] acc_times10;
  logic [63:0] acc_digit;
  logic [63:0] rate_sat;

  assign p     = head_item.cls.punct;
  assign ch    = head_item.data;
  assign digit = ch[3:0];

  // Decimal shift-add with saturation at the top of the 64-bit range.
  assign acc_times10 = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, digit};
  assign acc_digit   = ((acc > ACC_LIMIT) || ((acc == ACC_LIMIT) && (digit > 4'd5)))
                       ? '1 : acc_times10;
  assign rate_sat    = (acc[63:32] != '0) ? {32'd0, 32'hFFFF_FFFF} : acc;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    stage_next      = stage;
    status_next     = status;
    acc_next        = acc;
    start_time_next = start_time;
    kind            = TK_NONE;
    value           = '0;
    err             = 1'b0;

    if (head_item.restart) begin
      stage_next      = S_TYPE;
      status_next     = ST_GOOD;
      acc_next        = '0;
      start_time_next = '0;
    end else if (status == ST_GOOD) begin
      unique case (stage)
        S_TYPE: begin
          stage_next = S_GS_OPEN;
          if (head_item.cls.type_ok) begin
            kind  = TK_TYPE;
            value = {56'd0, ch};
          end else begin
            err = 1'b1;
          end
        end
        S_GS_OPEN: begin
          if (p == P_LPAREN) stage_next = S_GS_ID;
          else err = 1'b1;
        end
        S_GS_ID: begin
          if (p == P_RPAREN) begin
            stage_next = S_REL_SEP;
            kind       = TK_GS_END;
          end else if (head_item.cls.id_ok) begin
            kind  = TK_GS_CHAR;
            value = {56'd0, ch};
          end else begin
            err = 1'b1;
          end
        end
        S_REL_SEP: begin
          if (p == P_COMMA) begin
            acc_next   = '0;
            stage_next = S_REL;
          end else if (p == P_COLON) begin
            stage_next = S_ADDR_OPEN;
          end else if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        S_REL: begin
          if (p == P_COLON || p == P_END) begin
            // Values above the range are rejected, so no clamp is needed.
            if (acc < REL_MIN || acc > REL_MAX) begin
              err = 1'b1;
            end else begin
              kind       = TK_RELIABILITY;
              value      = acc;
              stage_next = S_ADDR_OPEN;
              if (p == P_END) status_next = ST_DONE;
            end
          end else if (head_item.cls.digit) begin
            acc_next = acc_digit;
          end else begin
            err = 1'b1;
          end
        end
        S_ADDR_OPEN: begin
          if (p == P_LPAREN) begin
            stage_next = S_ADDR;
          end else if (p == P_COLON) begin
            stage_next = S_NODES_OPEN;
          end else if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        S_ADDR: begin
          if (p == P_RPAREN) begin
            stage_next = S_ADDR_SEP;
            kind       = TK_ADDR_END;
          end else if (head_item.cls.addr_ok) begin
            kind  = TK_ADDR_CHAR;
            value = {56'd0, ch};
          end else begin
            err = 1'b1;
          end
        end
        S_ADDR_SEP: begin
          if (p == P_COLON) begin
            stage_next = S_NODES_OPEN;
          end else if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        S_NODES_OPEN: begin
          if (p == P_LBRACK) begin
            stage_next = S_NODE_OPEN;
          end else if (p == P_COLON) begin
            stage_next = S_CONTACTS_OPEN;
          end else if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        S_NODE_OPEN: begin
          if (p == P_LPAREN) stage_next = S_NODE_ID;
          else if (p == P_RBRACK) stage_next = S_NC_SEP;
          else err = 1'b1;
        end
        S_NODE_ID: begin
          if (p == P_RPAREN) begin
            stage_next = S_NODE_SEP;
            kind       = TK_NODE_END;
          end else if (head_item.cls.id_ok) begin
            kind  = TK_NODE_CHAR;
            value = {56'd0, ch};
          end else begin
            err = 1'b1;
          end
        end
        S_NODE_SEP: begin
          if (p == P_COMMA) stage_next = S_NODE_OPEN;
          else if (p == P_RBRACK) stage_next = S_NC_SEP;
          else err = 1'b1;
        end
        S_NC_SEP: begin
          if (p == P_COLON) begin
            stage_next = S_CONTACTS_OPEN;
          end else if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        S_CONTACTS_OPEN: begin
          if (p == P_LBRACK) begin
            stage_next = S_CONTACT_OPEN;
          end else if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        S_CONTACT_OPEN: begin
          if (p == P_LBRACE) begin
            acc_next   = '0;
            stage_next = S_START;
            kind       = TK_CONTACT;
          end else if (p == P_RBRACK) begin
            stage_next = S_FINAL;
          end else begin
            err = 1'b1;
          end
        end
        S_START: begin
          if (p == P_COMMA) begin
            start_time_next = acc;
            kind            = TK_START;
            value           = acc;
            acc_next        = '0;
            stage_next      = S_END;
          end else if (head_item.cls.digit) begin
            acc_next = acc_digit;
          end else begin
            err = 1'b1;
          end
        end
        S_END: begin
          if (p == P_COMMA) begin
            if ((acc > start_time) && (acc > head_item.now)) begin
              kind       = TK_END_TIME;
              value      = acc;
              acc_next   = '0;
              stage_next = S_RATE;
            end else begin
              err = 1'b1;
            end
          end else if (head_item.cls.digit) begin
            acc_next = acc_digit;
          end else begin
            err = 1'b1;
          end
        end
        S_RATE: begin
          if (p == P_COMMA || p == P_RBRACE) begin
            kind       = TK_BITRATE;
            value      = rate_sat;
            // A closing brace ends the contact together with the bitrate.
            stage_next = (p == P_COMMA) ? S_CNODES_OPEN : S_CONTACT_SEP;
          end else if (head_item.cls.digit) begin
            acc_next = acc_digit;
          end else begin
            err = 1'b1;
          end
        end
        S_CNODES_OPEN: begin
          if (p == P_LBRACK) stage_next = S_CNODE_OPEN;
          else err = 1'b1;
        end
        S_CNODE_OPEN: begin
          if (p == P_LPAREN) stage_next = S_CNODE_ID;
          else if (p == P_RBRACK) stage_next = S_CONTACT_CLOSE;
          else err = 1'b1;
        end
        S_CNODE_ID: begin
          if (p == P_RPAREN) begin
            stage_next = S_CNODE_SEP;
            kind       = TK_CNODE_END;
          end else if (head_item.cls.id_ok) begin
            kind  = TK_CNODE_CHAR;
            value = {56'd0, ch};
          end else begin
            err = 1'b1;
          end
        end
        S_CNODE_SEP: begin
          if (p == P_COMMA) stage_next = S_CNODE_OPEN;
          else if (p == P_RBRACK) stage_next = S_CONTACT_CLOSE;
          else err = 1'b1;
        end
        S_CONTACT_CLOSE: begin
          if (p == P_RBRACE) begin
            stage_next = S_CONTACT_SEP;
            kind       = TK_CLOSE;
          end else begin
            err = 1'b1;
          end
        end
        S_CONTACT_SEP: begin
          if (p == P_COMMA) stage_next = S_CONTACT_OPEN;
          else if (p == P_RBRACK) stage_next = S_FINAL;
          else err = 1'b1;
        end
        S_FINAL: begin
          if (p == P_END) begin
            status_next = ST_DONE;
            kind        = TK_DONE;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase

      if (err) begin
        status_next = ST_ERROR;
        kind        = TK_ERROR;
        value       = {56'd0, ch};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= S_TYPE;
      status     <= ST_GOOD;
      acc        <= '0;
      start_time <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        stage      <= stage_next;
        status     <= status_next;
        acc        <= acc_next;
        start_time <= start_time_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_reg <= status_next;
      kind_reg   <= kind;
      value_reg  <= value;
    end
  end

  assign parse_status = status_reg;
  assign token_kind   = kind_reg;
  assign token_value  = value_reg;

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.restart |=> status == ST_GOOD && stage == S_TYPE && acc == '0)
    else $error("restart did not return the parser to its initial state");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    pop && !head_item.restart && status == ST_ERROR |=> status == ST_ERROR)
    else $error("error status left without a restart");

  a_error_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_ERROR |-> parse_status == ST_ERROR)
    else $error("error token delivered without error status");

  a_done_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_DONE |-> parse_status == ST_DONE)
    else $error("done token delivered without done status");

  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == TK_END_TIME |-> token_value > start_time)
    else $error("contact end time not above its start time");

endmodule

`default_nettype wire

// File: rtl/core/route_command_stream_parser_top.sv
// Top level of the route command stream parser.
// Depends on rcsp_pkg, rcsp_front, rcsp_queue and rcsp_back.
//
//   Channel  Signals                                      Direction
//   input    in_valid/in_ready, req_type, data_byte,     in
//            now_seconds
//   result   out_valid/out_ready, parse_status,          out
//            token_kind, token_value
//   config   cfg_wr_en, cfg_index, cfg_data              in
//
// One byte is taken per cycle unless in_ready is low, and each byte gives one result;
// the grammar engine's decimal shift-add and time compares set the pace.
// A result passes through the queue and then the result register between its
// input transfer and its own transfer at the output.
// Reset clears the type range registers to 1..4, the queue, the result valid flag
// and the parser state; there is no clearing pass.
// The queue lets input transfers continue while a result waits on out_ready;
// in_ready falls only when the queue is full.
`default_nettype none

module route_command_stream_parser_top #(
  parameter int QueueDepth = rcsp_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_index,
  input  wire logic [rcsp_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           req_type,
  input  wire logic [7:0]                     data_byte,
  input  wire logic [63:0]                    now_seconds,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [1:0]                     parse_status,
  output      logic [4:0]                     token_kind,
  output      logic [63:0]                    token_value
);
  import rcsp_pkg::*;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  rcsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .now_seconds (now_seconds),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  rcsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  rcsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parse_status (parse_status),
    .token_kind   (token_kind),
    .token_value  (token_value)
  );

endmodule

`default_nettype wire
